### rtl/core/ssta_pkg.sv
// ----------------------------------------------------------------------------
// ssta_pkg
// Types and codes shared by the sprite slot table animator.
// ----------------------------------------------------------------------------
package ssta_pkg;

   localparam logic [3:0] REQ_TICK     = 4'd0;
   localparam logic [3:0] REQ_ADD      = 4'd1;
   localparam logic [3:0] REQ_REMOVE   = 4'd2;
   localparam logic [3:0] REQ_SET_ANIM = 4'd3;
   localparam logic [3:0] REQ_VISIBLE  = 4'd4;
   localparam logic [3:0] REQ_SET_X    = 4'd5;
   localparam logic [3:0] REQ_SET_Y    = 4'd6;
   localparam logic [3:0] REQ_PRIO     = 4'd7;
   localparam logic [3:0] REQ_READ     = 4'd8;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [7:0]  slot;
      logic [31:0] now_us;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] anim;
      logic [15:0] duration;
      logic [15:0] frame;
      logic [15:0] frame_limit;
      logic [15:0] frame_count;
      logic [15:0] anim_count;
      logic        flag;
   } req_item_type;

   // classified item handed from front to back
   typedef struct packed {
      req_item_type item;
      logic         in_range;
      logic         known;
   } cmd_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  result_slot;
      logic        cur_active;
      logic        cur_visible;
      logic        cur_priority;
      logic [15:0] cur_pos_x;
      logic [15:0] cur_pos_y;
      logic [15:0] cur_anim;
      logic [15:0] cur_frame;
      logic [15:0] cur_limit;
      logic [15:0] cur_duration;
   } rsp_item_type;

   typedef struct packed {
      logic        active;
      logic        visible;
      logic        prio;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] anim;
      logic [15:0] frame;
      logic [15:0] limit;
      logic [15:0] duration;
      logic [31:0] timer;
   } entry_type;

endpackage

### rtl/core/ssta_if.sv
// ----------------------------------------------------------------------------
// ssta_if
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface ssta_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  req_type;
   logic [7:0]  slot;
   logic [31:0] now_us;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] anim;
   logic [15:0] duration;
   logic [15:0] frame;
   logic [15:0] frame_limit;
   logic [15:0] frame_count;
   logic [15:0] anim_count;
   logic        flag;
   modport source (output valid, req_type, slot, now_us, pos_x, pos_y, anim, duration,
                   frame, frame_limit, frame_count, anim_count, flag, input ready);
   modport sink (input valid, req_type, slot, now_us, pos_x, pos_y, anim, duration,
                 frame, frame_limit, frame_count, anim_count, flag, output ready);
endinterface

interface ssta_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [7:0]  result_slot;
   logic        cur_active;
   logic        cur_visible;
   logic        cur_priority;
   logic [15:0] cur_pos_x;
   logic [15:0] cur_pos_y;
   logic [15:0] cur_anim;
   logic [15:0] cur_frame;
   logic [15:0] cur_limit;
   logic [15:0] cur_duration;
   modport source (output valid, ok, result_slot, cur_active, cur_visible, cur_priority,
                   cur_pos_x, cur_pos_y, cur_anim, cur_frame, cur_limit, cur_duration,
                   input ready);
   modport sink (input valid, ok, result_slot, cur_active, cur_visible, cur_priority,
                 cur_pos_x, cur_pos_y, cur_anim, cur_frame, cur_limit, cur_duration,
                 output ready);
endinterface

### rtl/core/ssta_front.sv
// ----------------------------------------------------------------------------
// ssta_front
// Accepts request items, classifies them and queues them (two deep).
// ----------------------------------------------------------------------------
module ssta_front
   import ssta_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic       clock,
   input  logic       reset,
   ssta_req_if.sink   req_chan,
   output cmd_type    cmd,
   output logic       cmd_valid,
   input  logic       cmd_pop
);

   cmd_type      ent_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push;
   cmd_type      new_cmd;

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign push           = req_chan.valid && req_chan.ready;
   assign cmd_valid      = (cnt_ff != 2'd0);
   assign cmd            = ent_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.item.req_type    = req_chan.req_type;
      new_cmd.item.slot        = req_chan.slot;
      new_cmd.item.now_us      = req_chan.now_us;
      new_cmd.item.pos_x       = req_chan.pos_x;
      new_cmd.item.pos_y       = req_chan.pos_y;
      new_cmd.item.anim        = req_chan.anim;
      new_cmd.item.duration    = req_chan.duration;
      new_cmd.item.frame       = req_chan.frame;
      new_cmd.item.frame_limit = req_chan.frame_limit;
      new_cmd.item.frame_count = req_chan.frame_count;
      new_cmd.item.anim_count  = req_chan.anim_count;
      new_cmd.item.flag        = req_chan.flag;
      new_cmd.in_range         = (32'(req_chan.slot) < 32'(SLOTS));
      new_cmd.known            = (req_chan.req_type <= REQ_READ);
   end

   always_comb begin
      wr_ptr_in = push    ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

### rtl/core/ssta_mod.sv
// ----------------------------------------------------------------------------
// ssta_mod
// Restoring remainder unit: 17-bit dividend by 16-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module ssta_mod
   import ssta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [16:0] num,
   input  logic [15:0] den,
   output logic        done,
   output logic [15:0] rem
);

   logic [16:0] num_ff, num_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] den_ff, den_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   assign done = done_ff;
   assign rem  = rem_ff[15:0];

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[16]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = 17'd0;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[15:0], 1'b0};
         if (trial >= {2'b00, den_ff}) begin
            rem_in = 17'(trial - {2'b00, den_ff});
         end else begin
            rem_in = trial[16:0];
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd16) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

### rtl/core/ssta_back.sv
// ----------------------------------------------------------------------------
// ssta_back
// Executes queued requests against the slot memory; holds the response.
// ----------------------------------------------------------------------------
module ssta_back
   import ssta_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      cmd_valid,
   output logic      cmd_pop,
   ssta_rsp_if.source rsp_chan
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;
   localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_WALK  = 4'b0100,
      ST_DIV   = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   cmd_type      cur_ff, cur_in;
   logic [CW-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CW-1:0] last_ff, last_in;
   logic         p_vld_ff, p_vld_in;
   logic [IW-1:0] p_idx_ff, p_idx_in;
   entry_type    hold_ff, hold_in;
   logic         rsp_vld_ff, rsp_vld_in;
   rsp_item_type rsp_ff, rsp_in;

   entry_type    mem [SLOTS];
   entry_type    rd_q_ff;
   logic         re;
   logic         we;
   logic [IW-1:0] wa;
   entry_type    wd;

   logic         div_start;
   logic         div_done;
   logic [15:0]  div_rem;
   logic [16:0]  fr1;
   logic         advance;
   logic         is_last;
   entry_type    e;
   entry_type    upd;
   req_item_type it;
   rsp_item_type fin;

   ssta_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (fr1),
      .den   (e.limit),
      .done  (div_done),
      .rem   (div_rem)
   );

   assign e  = rd_q_ff;
   assign it = cur_ff.item;
   assign fr1 = {1'b0, e.frame} + 17'd1;
   assign advance = e.active && e.visible && (e.duration != 16'd0)
                    && ((it.now_us - {16'd0, e.duration}) > e.timer);
   assign is_last = ({1'b0, p_idx_ff} == last_ff);

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.ok           = rsp_ff.ok;
   assign rsp_chan.result_slot  = rsp_ff.result_slot;
   assign rsp_chan.cur_active   = rsp_ff.cur_active;
   assign rsp_chan.cur_visible  = rsp_ff.cur_visible;
   assign rsp_chan.cur_priority = rsp_ff.cur_priority;
   assign rsp_chan.cur_pos_x    = rsp_ff.cur_pos_x;
   assign rsp_chan.cur_pos_y    = rsp_ff.cur_pos_y;
   assign rsp_chan.cur_anim     = rsp_ff.cur_anim;
   assign rsp_chan.cur_frame    = rsp_ff.cur_frame;
   assign rsp_chan.cur_limit    = rsp_ff.cur_limit;
   assign rsp_chan.cur_duration = rsp_ff.cur_duration;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      rd_cnt_in  = rd_cnt_ff;
      last_in    = last_ff;
      p_vld_in   = 1'b0;
      p_idx_in   = p_idx_ff;
      hold_in    = hold_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_chan.ready;
      rsp_in     = rsp_ff;
      cmd_pop    = 1'b0;
      re         = 1'b0;
      we         = 1'b0;
      wa         = p_idx_ff;
      wd         = e;
      upd        = e;
      div_start  = 1'b0;
      fin        = '0;

      case (state_ff)
         ST_CLEAR: begin
            we        = 1'b1;
            wa        = rd_cnt_ff[IW-1:0];
            wd        = '0;
            rd_cnt_in = rd_cnt_ff + CW'(1);
            if (rd_cnt_ff == LAST_SLOT) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && !rsp_vld_ff) begin
               cmd_pop = 1'b1;
               cur_in  = cmd;
               if (cmd.item.req_type == REQ_TICK || cmd.item.req_type == REQ_ADD) begin
                  rd_cnt_in = '0;
                  last_in   = LAST_SLOT;
                  state_in  = ST_WALK;
               end else if (cmd.known && cmd.in_range) begin
                  rd_cnt_in = CW'(cmd.item.slot);
                  last_in   = CW'(cmd.item.slot);
                  state_in  = ST_WALK;
               end else begin
                  // unknown request or slot beyond the table
                  fin = '0;
                  if (cmd.item.req_type == REQ_READ) begin
                     fin.result_slot = cmd.item.slot;
                  end
                  rsp_in     = fin;
                  rsp_vld_in = 1'b1;
               end
            end
         end
         ST_WALK: begin
            // issue the next read while the previous entry is processed
            if (rd_cnt_ff <= last_ff) begin
               re        = 1'b1;
               p_vld_in  = 1'b1;
               p_idx_in  = rd_cnt_ff[IW-1:0];
               rd_cnt_in = rd_cnt_ff + CW'(1);
            end
            if (p_vld_ff) begin
               fin.ok = 1'b1;
               case (it.req_type)
                  REQ_TICK: begin
                     if (advance) begin
                        upd.timer = it.now_us;
                        if (e.limit == 16'd0 || fr1 == {1'b0, e.limit}) begin
                           upd.frame = 16'd0;
                        end else begin
                           upd.frame = fr1[15:0];
                        end
                        if (e.limit != 16'd0 && fr1 > {1'b0, e.limit}) begin
                           // next frame beyond its limit: take the full remainder
                           div_start = 1'b1;
                           hold_in   = upd;
                           rd_cnt_in = CW'(p_idx_ff) + CW'(1);
                           p_vld_in  = 1'b0;
                           p_idx_in  = p_idx_ff;
                           state_in  = ST_DIV;
                        end else begin
                           we = 1'b1;
                           wd = upd;
                        end
                     end
                     if (is_last && state_in != ST_DIV) begin
                        rsp_in     = fin;
                        rsp_vld_in = 1'b1;
                        p_vld_in   = 1'b0;
                        state_in   = ST_IDLE;
                     end
                  end
                  REQ_ADD: begin
                     if (!e.active) begin
                        upd          = '0;
                        upd.active   = 1'b1;
                        upd.visible  = 1'b1;
                        upd.pos_x    = it.pos_x;
                        upd.pos_y    = it.pos_y;
                        upd.limit    = it.frame_count;
                        we           = 1'b1;
                        wd           = upd;
                        fin.result_slot = 8'(p_idx_ff);
                        rsp_in       = fin;
                        rsp_vld_in   = 1'b1;
                        p_vld_in     = 1'b0;
                        state_in     = ST_IDLE;
                     end else if (is_last) begin
                        fin.ok     = 1'b0;
                        rsp_in     = fin;
                        rsp_vld_in = 1'b1;
                        p_vld_in   = 1'b0;
                        state_in   = ST_IDLE;
                     end
                  end
                  default: begin
                     // single-slot requests
                     case (it.req_type)
                        REQ_REMOVE:  upd.active  = 1'b0;
                        REQ_VISIBLE: upd.visible = it.flag;
                        REQ_PRIO:    upd.prio    = it.flag;
                        REQ_SET_X:   upd.pos_x   = it.pos_x;
                        REQ_SET_Y:   upd.pos_y   = it.pos_y;
                        REQ_SET_ANIM: begin
                           upd.timer    = it.now_us;
                           upd.anim     = it.anim;
                           upd.frame    = it.frame;
                           upd.duration = it.duration;
                           upd.limit    = it.frame_limit;
                        end
                        default: upd = e;
                     endcase
                     if (it.req_type == REQ_SET_ANIM &&
                         !(it.anim < it.anim_count && it.frame < it.frame_count)) begin
                        fin.ok = 1'b0;
                     end else if (it.req_type != REQ_READ) begin
                        we = 1'b1;
                        wd = upd;
                     end
                     if (it.req_type == REQ_READ) begin
                        fin.result_slot  = it.slot;
                        fin.cur_active   = e.active;
                        fin.cur_visible  = e.visible;
                        fin.cur_priority = e.prio;
                        fin.cur_pos_x    = e.pos_x;
                        fin.cur_pos_y    = e.pos_y;
                        fin.cur_anim     = e.anim;
                        fin.cur_frame    = e.frame;
                        fin.cur_limit    = e.limit;
                        fin.cur_duration = e.duration;
                     end
                     rsp_in     = fin;
                     rsp_vld_in = 1'b1;
                     p_vld_in   = 1'b0;
                     state_in   = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               upd       = hold_ff;
               upd.frame = div_rem;
               we        = 1'b1;
               wd        = upd;
               if (is_last) begin
                  fin.ok     = 1'b1;
                  rsp_in     = fin;
                  rsp_vld_in = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         rd_cnt_ff  <= '0;
         last_ff    <= '0;
         p_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_cnt_ff  <= rd_cnt_in;
         last_ff    <= last_in;
         p_vld_ff   <= p_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      p_idx_ff <= p_idx_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_q_ff <= mem[rd_cnt_ff[IW-1:0]];
      end
   end

endmodule

### rtl/core/sprite_slot_table_animator_top.sv
// ----------------------------------------------------------------------------
// sprite_slot_table_animator_top
// Sprite slot table with per-slot frame animation.
// ----------------------------------------------------------------------------
// A table of SLOTS sprite slots held in one single-port-write memory. Each
// request item gives exactly one response item. A tick walks every slot
// through the memory read port, one slot a cycle while no remainder is
// being taken; a slot whose next frame passes its limit stalls the walk for
// the bit-serial remainder. Add walks from slot 0 up to the first inactive
// slot. Remove, set, and read do one memory read, then one update (a read
// writes nothing). An unknown request or an out-of-range slot is answered
// without a memory access. After reset the memory is cleared, one slot a
// cycle; items are queued but not executed until that ends. The front queue
// holds two items, so requests are taken while a response waits.
// ----------------------------------------------------------------------------
module sprite_slot_table_animator_top
   import ssta_pkg::*;
#(
   parameter int SLOTS = 256
) (
   input  logic        clock,
   input  logic        reset,
   ssta_req_if.sink    req_chan,
   ssta_rsp_if.source  rsp_chan
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // front: accept and classify, two-item queue
   ssta_front #(.SLOTS(SLOTS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   // back: memory walk, update and response register
   ssta_back #(.SLOTS(SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
